@@ design/assert_macros.svh @@
// Assertion macros shared by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, clocked on clk, off during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/ubh_pkg.sv @@
// Types, constants and codes of the uniform-bin histogram.
package ubh_pkg;

	localparam int BIN_DEPTH_DEF   = 64;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int SAMPLE_W  = 32;
	localparam int BIN_W     = 6;
	localparam int NBINS_W   = 7;
	localparam int COUNT_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam int QUO_W      = NBINS_W;
	localparam int DIV_STEPS  = QUO_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int DIVISOR_W  = SAMPLE_W;
	localparam int DIVIDEND_W = DIVISOR_W + QUO_W;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 2'd2;

	localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = 32'h0000_0000;
	localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = 32'h0001_0000;
	localparam logic [NBINS_W-1:0]  BIN_COUNT_RST  = 7'd64;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_START,
		S_DIV,
		S_FETCH,
		S_UPDATE
	} ubh_state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ design/ubh_if.sv @@
// Request and result channel interfaces of the histogram.
interface ubh_in_if;
	import ubh_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic [BIN_W-1:0]           read_bin;
	modport source (output valid, command, sample_value, read_bin, input ready);
	modport sink (input valid, command, sample_value, read_bin, output ready);
endinterface

interface ubh_out_if;
	import ubh_pkg::*;
	logic               valid;
	logic               ready;
	logic               in_range;
	logic [BIN_W-1:0]   bin_index;
	logic [COUNT_W-1:0] count_value;
	modport source (output valid, in_range, bin_index, count_value, input ready);
	modport sink (input valid, in_range, bin_index, count_value, output ready);
endinterface

@@ design/ubh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ubh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ design/ubh_div.sv @@
// Restoring divider, one quotient bit per cycle over a shared subtractor.
module ubh_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ubh_pkg::div_req_t req,
	output ubh_pkg::div_rsp_t rsp
);
	import ubh_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [QUO_W-1:0]     sh_q;
	logic [QUO_W-1:0]     quo_q;

	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] trial_sub;
	logic               ge;

	assign trial     = {rem_q, sh_q[QUO_W-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign ge        = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[DIVIDEND_W-1:QUO_W];
			sh_q  <= req.dividend[QUO_W-1:0];
			dsr_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

@@ design/uniform_bin_histogram.sv @@
// Top level of the uniform-bin histogram: sequencer, datapath and counter store.
//
//   channel  | dir | payload                               | accepted when
//   in_ch    | in  | command, sample_value, read_bin       | valid && ready
//   out_ch   | out | in_range, bin_index, count_value      | valid && ready
//   cfg      | in  | cfg_index, cfg_data                   | cfg_we
//
// A counted sample in the range but below its high edge goes through prep, the start
// of the 7-step restoring divider, the divider itself, one RAM read and one write
// before its result shows and the next request is taken. A read, a skipped sample
// or a sample on the high edge skips the divider: prep leads straight to the RAM read.
// After reset a clearing pass writes zero to all BIN_DEPTH counters, one a cycle.
// in_ch.ready stays low during that pass and while an item is at work; a stalled
// out_ch holds the finished result and the next one waits in the update step.
`include "assert_macros.svh"

module uniform_bin_histogram #(
	parameter int BIN_DEPTH   = ubh_pkg::BIN_DEPTH_DEF,
	parameter int COUNT_WIDTH = ubh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ubh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ubh_pkg::CFG_DAT_W-1:0]  cfg_data,
	ubh_in_if.sink                         in_ch,
	ubh_out_if.source                      out_ch
);
	import ubh_pkg::*;

	localparam int AW    = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
	localparam int DEP_W = 13;

	ubh_state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] low_q;
	logic signed [SAMPLE_W-1:0] high_q;
	logic [NBINS_W-1:0]         nbins_q;

	logic                       cmd_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [BIN_W-1:0]           rbin_q;
	logic                       hit_q;
	logic [NBINS_W-1:0]         idx_q;
	logic [DIVISOR_W-1:0]       span_q;
	logic [DIVIDEND_W-1:0]      dividend_q;
	logic [AW-1:0]              clr_q;

	logic               out_valid_q;
	logic               out_hit_q;
	logic [BIN_W-1:0]   out_idx_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic               accept;
	logic               out_free;
	logic               out_load;
	logic               div_start;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic [DEP_W-1:0]   n_wide;
	logic [NBINS_W-1:0] n;
	logic [SAMPLE_W:0]  diff_x;
	logic [SAMPLE_W:0]  span_x;
	logic               add_hit;
	logic               on_edge;
	logic [DIVIDEND_W-1:0] prod;
	logic [NBINS_W-1:0] quo_clamped;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]          idx_addr;
	logic [AW+NBINS_W-1:0]  idx_wide;
	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [COUNT_WIDTH-1:0] cnt_sel;
	logic [COUNT_WIDTH+COUNT_W-1:0] cnt_wide;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= RANGE_LOW_RST;
			high_q  <= RANGE_HIGH_RST;
			nbins_q <= BIN_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_LOW:  low_q   <= cfg_data[SAMPLE_W-1:0];
				REG_RANGE_HIGH: high_q  <= cfg_data[SAMPLE_W-1:0];
				REG_BIN_COUNT:  nbins_q <= cfg_data[NBINS_W-1:0];
				default: ;
			endcase
		end
	end

	// bins in use and range checks
	assign n_wide = ({6'b0, nbins_q} > DEP_W'(BIN_DEPTH)) ? DEP_W'(BIN_DEPTH)
	                                                       : {6'b0, nbins_q};
	assign n       = n_wide[NBINS_W-1:0];
	assign diff_x  = {sample_q[SAMPLE_W-1], sample_q} - {low_q[SAMPLE_W-1], low_q};
	assign span_x  = {high_q[SAMPLE_W-1], high_q} - {low_q[SAMPLE_W-1], low_q};
	assign add_hit = (n != '0) && (high_q > low_q) && (sample_q >= low_q)
	                 && (sample_q <= high_q);
	assign on_edge = sample_q == high_q;
	assign prod    = {{QUO_W{1'b0}}, diff_x[SAMPLE_W-1:0]} * {{DIVISOR_W{1'b0}}, n};
	assign quo_clamped = (div_rsp.quotient >= n) ? n - 1'b1 : div_rsp.quotient;

	// counter store addressing
	assign idx_wide = {{AW{1'b0}}, idx_q};
	assign idx_addr = idx_wide[AW-1:0];
	assign cnt_inc  = (rdata == {COUNT_WIDTH{1'b1}}) ? rdata : rdata + 1'b1;
	assign cnt_sel  = !hit_q ? '0 : ((cmd_q == CMD_ADD) ? cnt_inc : rdata);
	assign cnt_wide = {{COUNT_W{1'b0}}, cnt_sel};

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		div_start   = 1'b0;
		out_load    = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = idx_addr;
		ram_wdata   = cnt_inc;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(BIN_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (cmd_q == CMD_ADD && add_hit && !on_edge) begin
					state_d = S_START;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_START: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (out_free) begin
					out_load = 1'b1;
					ram_we   = hit_q && (cmd_q == CMD_ADD);
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == S_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_ch.command;
			sample_q <= in_ch.sample_value;
			rbin_q   <= in_ch.read_bin;
		end
		case (state_q)
			S_PREP: begin
				if (cmd_q == CMD_READ) begin
					hit_q <= {1'b0, rbin_q} < n;
					idx_q <= {1'b0, rbin_q};
				end else begin
					hit_q <= add_hit;
					idx_q <= (add_hit && on_edge) ? n - 1'b1 : '0;
				end
				span_q     <= span_x[SAMPLE_W-1:0];
				dividend_q <= prod;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					idx_q <= quo_clamped;
				end
			end
			default: ;
		endcase
	end

	assign div_req.start    = div_start;
	assign div_req.dividend = dividend_q;
	assign div_req.divisor  = span_q;

	ubh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ubh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (BIN_DEPTH)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_addr),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hit_q <= hit_q;
			out_idx_q <= idx_q[BIN_W-1:0];
			out_cnt_q <= cnt_wide[COUNT_W-1:0];
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.in_range    = out_hit_q;
	assign out_ch.bin_index   = out_idx_q;
	assign out_ch.count_value = out_cnt_q;

	`ASSERT_IMP(a_we_state, ram_we, (state_q == S_CLEAR) || (state_q == S_UPDATE), "counter write outside clear or update")
	`ASSERT_IMP(a_bin_bound, out_load && hit_q && (cmd_q == CMD_ADD), idx_q < n, "counted bin beyond bins in use")
	`ASSERT_IMP(a_div_done, div_rsp.done, state_q == S_DIV, "divider finished while not awaited")
	`ASSERT_NXT(a_accept_prep, accept, state_q == S_PREP, "accepted request not taken to prep")
	`ASSERT_IMP(a_load_free, out_load, out_free, "result overwrites an undelivered one")

endmodule

@@ bench/uniform_bin_histogram_test.sv @@
// Self-checking bench for the uniform-bin histogram: directed edges, then random phases.
module uniform_bin_histogram_test;
	import ubh_pkg::*;

	localparam longint Q_MIN = -64'sd2147483648;
	localparam longint Q_MAX = 64'sd2147483647;

	typedef struct {
		logic               in_range;
		logic [BIN_W-1:0]   bin_index;
		logic [COUNT_W-1:0] count_value;
	} bin_result_t;

	class histogram_checker;
		logic signed [SAMPLE_W-1:0] range_low;
		logic signed [SAMPLE_W-1:0] range_high;
		logic [NBINS_W-1:0]         bin_count;
		logic [COUNT_W-1:0]         bin_tally [BIN_DEPTH_DEF];
		bin_result_t                pending_results [$];
		int                         errors;

		function new();
			range_low = RANGE_LOW_RST;
			range_high = RANGE_HIGH_RST;
			bin_count = BIN_COUNT_RST;
			foreach (bin_tally[i]) bin_tally[i] = '0;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
			case (index)
				REG_RANGE_LOW: range_low = data;
				REG_RANGE_HIGH: range_high = data;
				REG_BIN_COUNT: bin_count = data[NBINS_W-1:0];
				default: ;
			endcase
		endfunction

		function int bins_in_use();
			return (bin_count > BIN_DEPTH_DEF) ? BIN_DEPTH_DEF : int'(bin_count);
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void add_request(logic command, logic signed [SAMPLE_W-1:0] value,
				logic [BIN_W-1:0] read_bin);
			bin_result_t r;
			longint lo, hi, v;
			int n, b;
			n = bins_in_use();
			lo = range_low;
			hi = range_high;
			v = value;
			r.in_range = 1'b0;
			r.bin_index = '0;
			r.count_value = '0;
			if (command == CMD_READ) begin
				r.bin_index = read_bin;
				if (read_bin < n) begin
					r.in_range = 1'b1;
					r.count_value = bin_tally[read_bin];
				end
			end else if (n > 0 && hi > lo && v >= lo && v <= hi) begin
				if (v == hi)
					b = n - 1;
				else
					b = int'((v - lo) * n / (hi - lo));
				if (b >= n)
					b = n - 1;
				if (bin_tally[b] != '1)
					bin_tally[b]++;
				r.in_range = 1'b1;
				r.bin_index = b[BIN_W-1:0];
				r.count_value = bin_tally[b];
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(logic in_range, logic [BIN_W-1:0] bin_index,
				logic [COUNT_W-1:0] count_value);
			bin_result_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected result: in_range %0b bin_index %0d count_value %0d",
					in_range, bin_index, count_value);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (in_range !== e.in_range) begin
				$error("in_range: expected %0b, got %0b", e.in_range, in_range);
				errors++;
			end
			if (bin_index !== e.bin_index) begin
				$error("bin_index: expected %0d, got %0d", e.bin_index, bin_index);
				errors++;
			end
			if (count_value !== e.count_value) begin
				$error("count_value: expected %0d, got %0d", e.count_value, count_value);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	bit                   bursty = 1'b1;
	bit                   long_hold = 1'b0;

	ubh_in_if  in_ch ();
	ubh_out_if out_ch ();

	histogram_checker tracker = new();

	uniform_bin_histogram DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				tracker.add_request(in_ch.command, in_ch.sample_value, in_ch.read_bin);
			if (out_ch.valid && out_ch.ready)
				tracker.check_result(out_ch.in_range, out_ch.bin_index, out_ch.count_value);
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (bursty && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic offer(input logic cmd, input logic [SAMPLE_W-1:0] value,
			input logic [BIN_W-1:0] rb);
		if (bursty && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.sample_value <= value;
		in_ch.read_bin <= rb;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi,
			input logic [NBINS_W-1:0] n);
		logic [CFG_DAT_W-1:0] n_word;
		n_word = {25'($urandom), n};
		cfg_we <= 1'b1;
		cfg_index <= REG_RANGE_LOW;
		cfg_data <= lo;
		tracker.set_register(REG_RANGE_LOW, lo);
		@(posedge clk);
		cfg_index <= REG_RANGE_HIGH;
		cfg_data <= hi;
		tracker.set_register(REG_RANGE_HIGH, hi);
		@(posedge clk);
		cfg_index <= REG_BIN_COUNT;
		cfg_data <= n_word;
		tracker.set_register(REG_BIN_COUNT, n_word);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int items);
		longint lo, hi, span, v, ofs;
		logic [NBINS_W-1:0] n;
		logic [BIN_W-1:0] rb;
		logic cmd;
		int nu, k, sel;
		case ($urandom_range(0, 4))
			0: lo = Q_MIN;
			1: lo = longint'($signed($urandom));
			2: lo = -longint'($urandom_range(1, 1 << 20));
			3: lo = 0;
			default: lo = longint'($urandom_range(0, 1 << 20));
		endcase
		case ($urandom_range(0, 7))
			0: hi = Q_MAX;
			1: hi = lo + longint'($urandom_range(1, 200));
			2: hi = lo - longint'($urandom_range(0, 1000));
			default: hi = lo + longint'($urandom_range(1, 32'h7FFF_FFFF));
		endcase
		if (hi > Q_MAX)
			hi = Q_MAX;
		if (hi < Q_MIN)
			hi = Q_MIN;
		case ($urandom_range(0, 9))
			0: n = 7'd0;
			1: n = 7'd1;
			2: n = 7'd64;
			3: n = NBINS_W'($urandom_range(65, 127));
			default: n = NBINS_W'($urandom_range(2, 63));
		endcase
		configure(lo[31:0], hi[31:0], n);
		nu = tracker.bins_in_use();
		span = hi - lo;
		for (k = 0; k < items; k++) begin
			cmd = CMD_ADD;
			v = longint'($signed($urandom));
			rb = BIN_W'($urandom_range(0, 63));
			sel = $urandom_range(0, 99);
			if (sel < 20) begin
				cmd = CMD_READ;
				if (nu > 0 && sel < 12)
					rb = BIN_W'($urandom_range(0, nu - 1));
			end else if (sel < 32) begin
				case ($urandom_range(0, 3))
					0: v = lo;
					1: v = hi;
					2: v = lo - 1;
					default: v = hi + 1;
				endcase
			end else if (sel < 50 && hi > lo && nu > 0) begin
				ofs = longint'($urandom_range(0, nu - 1));
				v = lo + (ofs * span + nu - 1) / nu - longint'($urandom_range(0, 1));
			end else if (sel >= 50 && hi > lo) begin
				v = lo + longint'({$urandom, $urandom} % (span + 1));
			end
			offer(cmd, v[31:0], rb);
		end
		drain();
	endtask

	initial begin
		int p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_ADD;
		in_ch.sample_value = '0;
		in_ch.read_bin = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		offer(CMD_READ, 32'h0000_0000, 6'd0);
		offer(CMD_READ, 32'hFFFF_FFFF, 6'd63);
		offer(CMD_ADD, 32'h0000_0000, 6'd0);
		offer(CMD_ADD, 32'h0001_0000, 6'd63);
		offer(CMD_ADD, 32'h0000_FFFF, 6'd0);
		offer(CMD_ADD, 32'hFFFF_FFFF, 6'd0);
		offer(CMD_ADD, 32'h0001_0001, 6'd0);
		offer(CMD_ADD, 32'h0000_8000, 6'd0);
		offer(CMD_READ, 32'h0000_0000, 6'd63);
		drain();

		configure(32'h8000_0000, 32'h7FFF_FFFF, 7'd127);
		offer(CMD_ADD, 32'h8000_0000, 6'd0);
		offer(CMD_ADD, 32'h7FFF_FFFF, 6'd0);
		offer(CMD_ADD, 32'h7FFF_FFFE, 6'd0);
		offer(CMD_ADD, 32'h0000_0000, 6'd0);
		offer(CMD_READ, 32'h0000_0000, 6'd63);
		drain();

		configure(32'h0000_1234, 32'h0000_1234, 7'd64);
		offer(CMD_ADD, 32'h0000_1234, 6'd0);
		drain();

		configure(32'h0000_0005, 32'hFFFF_FFFB, 7'd64);
		offer(CMD_ADD, 32'h0000_0000, 6'd0);
		drain();

		configure(32'h0000_0000, 32'h0001_0000, 7'd0);
		offer(CMD_ADD, 32'h0000_8000, 6'd0);
		offer(CMD_READ, 32'h0000_0000, 6'd0);
		drain();

		configure(32'h0000_0000, 32'h0001_0000, 7'd1);
		offer(CMD_ADD, 32'h0001_0000, 6'd0);
		offer(CMD_ADD, 32'h0000_0001, 6'd0);
		offer(CMD_READ, 32'h0000_0000, 6'd1);
		offer(CMD_READ, 32'h0000_0000, 6'd0);
		drain();

		for (p = 0; p < 12; p++) begin
			if (p == 3 || p == 8)
				long_hold = 1'b1;
			random_phase(60);
		end
		bursty = 1'b0;
		random_phase(50);

		repeat (30) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
